// ===== rtl/core/dntd_pkg.sv =====
package dntd_pkg;

    // field widths
    localparam int POS_W    = 24;
    localparam int FRAC_W   = 8;
    localparam int BRIGHT_W = 8 + FRAC_W;
    localparam int CNT_W    = 8;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCURSIONS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_POS  = 2'd3;

    // reset values of the configuration registers
    localparam logic [BRIGHT_W-1:0] TOLERANCE_RST  = BRIGHT_W'(2560);
    localparam logic [CNT_W-1:0]    EXCURSIONS_RST = CNT_W'(3);
    localparam logic [POS_W-1:0]    MIN_LENGTH_RST = POS_W'(100);
    localparam logic [POS_W-1:0]    FIRST_POS_RST  = '0;

    // saturation limit of the excursion counter
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [BRIGHT_W-1:0] tolerance;
        logic [CNT_W-1:0]    excursions;
        logic [POS_W-1:0]    min_length;
        logic [POS_W-1:0]    first_pos;
    } t_cfg;

    typedef struct packed {
        logic                started;
        logic [BRIGHT_W-1:0] ref_bright;
        logic [POS_W-1:0]    settled_pos;
        logic [CNT_W-1:0]    exc_count;
        logic [POS_W-1:0]    last_bp;
    } t_state;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] bp_pos;
        logic             is_day;
        logic             skipped;
    } t_result;

endpackage

// ===== rtl/core/day_night_transition_detector.sv =====
// channel  | direction | handshake                 | payload
// frame in | in        | i_in_valid / o_in_stall   | i_frame_position, i_frame_brightness
// result   | out       | o_out_valid / i_out_stall | o_breakpoint_found, o_breakpoint_position,
//          |           |                           | o_new_period_is_day, o_frame_skipped
// config   | in        | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// one frame per cycle unless stalled; its result appears in the next cycle.
// the state update and the result come from one pass of compare and count logic.
// synchronous active-low reset clears state, config to defaults and the result valid flag.
// the input stalls only while a held result is itself stalled downstream.
module day_night_transition_detector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [dntd_pkg::POS_W-1:0]        i_frame_position,
    input  logic [dntd_pkg::BRIGHT_W-1:0]     i_frame_brightness,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_breakpoint_found,
    output logic [dntd_pkg::POS_W-1:0]        o_breakpoint_position,
    output logic                              o_new_period_is_day,
    output logic                              o_frame_skipped,
    input  logic                              i_cfg_we,
    input  logic [dntd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dntd_pkg::CFG_W-1:0]        i_cfg_data
);
    import dntd_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;
    logic    in_accept;

    // handshake: input waits only while held result is stalled
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tolerance  <= TOLERANCE_RST;
            r_cfg.excursions <= EXCURSIONS_RST;
            r_cfg.min_length <= MIN_LENGTH_RST;
            r_cfg.first_pos  <= FIRST_POS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TOLERANCE:  r_cfg.tolerance  <= i_cfg_data[BRIGHT_W-1:0];
                CFG_EXCURSIONS: r_cfg.excursions <= i_cfg_data[CNT_W-1:0];
                CFG_MIN_LENGTH: r_cfg.min_length <= i_cfg_data[POS_W-1:0];
                CFG_FIRST_POS:  r_cfg.first_pos  <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // per-frame evaluation
    dntd_eval u_eval (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_pos    (i_frame_position),
        .i_bright (i_frame_brightness),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_breakpoint_found    = r_result.found;
    assign o_breakpoint_position = r_result.bp_pos;
    assign o_new_period_is_day   = r_result.is_day;
    assign o_frame_skipped       = r_result.skipped;

`ifndef ASSERT_OFF
    a_found_not_skipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_breakpoint_found |-> !o_frame_skipped)
        else $error("breakpoint reported on a skipped frame");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.started |-> (r_state.exc_count == '0))
        else $error("excursions counted before start");

    a_bp_recorded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && n_result.found |=> (r_state.last_bp == o_breakpoint_position))
        else $error("breakpoint not recorded as last breakpoint");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> o_out_valid && $stable(r_state))
        else $error("state moved while result held");
`endif

endmodule

// ===== rtl/core/dntd_eval.sv =====
module dntd_eval (
    input  dntd_pkg::t_cfg                     i_cfg,
    input  dntd_pkg::t_state                   i_state,
    input  logic [dntd_pkg::POS_W-1:0]         i_pos,
    input  logic [dntd_pkg::BRIGHT_W-1:0]      i_bright,
    output dntd_pkg::t_state                   o_state,
    output dntd_pkg::t_result                  o_result
);
    import dntd_pkg::*;

    logic [CNT_W-1:0]    need;
    logic                rising;
    logic [BRIGHT_W-1:0] diff;

    // a zero excursion requirement behaves as one
    assign need   = (i_cfg.excursions == '0) ? CNT_W'(1) : i_cfg.excursions;
    assign rising = i_bright > i_state.ref_bright;
    assign diff   = rising ? (i_bright - i_state.ref_bright)
                           : (i_state.ref_bright - i_bright);

    // next state and result for one frame
    always_comb begin
        logic [CNT_W-1:0] cnt_next;
        cnt_next = i_state.exc_count;
        o_state  = i_state;
        o_result = '0;
        if (!i_state.started) begin
            if (i_pos == i_cfg.first_pos) begin
                o_state.started     = 1'b1;
                o_state.ref_bright  = i_bright;
                o_state.settled_pos = i_pos;
                o_state.exc_count   = '0;
                o_state.last_bp     = i_pos;
            end else begin
                o_result.skipped = 1'b1;
            end
        end else if (i_pos <= i_state.settled_pos) begin
            // rewound frame, already covered
            o_result.skipped = 1'b1;
        end else if (i_pos == i_cfg.first_pos) begin
            o_state.ref_bright  = i_bright;
            o_state.settled_pos = i_pos;
            o_state.exc_count   = '0;
            o_state.last_bp     = i_pos;
        end else begin
            // count excursions, steady frame re-references
            if (diff > i_cfg.tolerance) begin
                if (i_state.exc_count != CNT_MAX) begin
                    cnt_next = i_state.exc_count + 1'b1;
                end
                o_state.exc_count = cnt_next;
            end else begin
                cnt_next            = '0;
                o_state.ref_bright  = i_bright;
                o_state.settled_pos = i_pos;
                o_state.exc_count   = '0;
            end
            // enough excursions in a row
            if (cnt_next == need) begin
                if ((i_pos >= i_state.last_bp)
                        && ((i_pos - i_state.last_bp) > i_cfg.min_length)) begin
                    o_result.found  = 1'b1;
                    o_result.bp_pos = i_state.settled_pos + 1'b1;
                    o_result.is_day = rising;
                    o_state.last_bp = i_state.settled_pos + 1'b1;
                end
                o_state.ref_bright  = i_bright;
                o_state.settled_pos = i_pos;
                o_state.exc_count   = '0;
            end
        end
    end

endmodule

// ===== verif/day_night_transition_detector_checker.sv =====
module day_night_transition_detector_checker
    import dntd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [POS_W-1:0]     i_frame_position,
    input  logic [BRIGHT_W-1:0]  i_frame_brightness,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_breakpoint_found,
    input  logic [POS_W-1:0]     i_breakpoint_position,
    input  logic                 i_new_period_is_day,
    input  logic                 i_frame_skipped,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    // shadow of the registers and of the detector state
    t_cfg    settings;
    t_state  tracker;
    logic    period_day;
    t_result expected_verdicts[$];

    // take this frame as the new reference
    function automatic void settle_reference(input logic [POS_W-1:0] pos,
                                             input logic [BRIGHT_W-1:0] br);
        tracker.ref_bright  = br;
        tracker.settled_pos = pos;
        tracker.exc_count   = '0;
    endfunction

    // one frame through the detector: updates the shadow state, returns its verdict
    function automatic t_result judge_frame(input logic [POS_W-1:0] pos,
                                            input logic [BRIGHT_W-1:0] br);
        t_result             verdict;
        logic [CNT_W-1:0]    need;
        logic                rising;
        logic [BRIGHT_W-1:0] diff;
        logic [POS_W-1:0]    span;
        logic [POS_W-1:0]    bp;
        verdict = '0;
        need    = (settings.excursions == '0) ? CNT_W'(1) : settings.excursions;
        if (!tracker.started) begin
            if (pos == settings.first_pos) begin
                tracker.started = 1'b1;
                settle_reference(pos, br);
                tracker.last_bp = pos;
            end else begin
                verdict.skipped = 1'b1;
            end
        end else if (pos <= tracker.settled_pos) begin
            verdict.skipped = 1'b1;
        end else if (pos == settings.first_pos) begin
            settle_reference(pos, br);
            tracker.last_bp = pos;
        end else begin
            rising = br > tracker.ref_bright;
            diff   = rising ? br - tracker.ref_bright : tracker.ref_bright - br;
            // excursion count saturates, a steady frame re-references
            if (diff > settings.tolerance) begin
                if (tracker.exc_count != CNT_MAX)
                    tracker.exc_count = tracker.exc_count + 1'b1;
            end else begin
                settle_reference(pos, br);
            end
            if (tracker.exc_count == need) begin
                span = (pos >= tracker.last_bp) ? pos - tracker.last_bp : '0;
                // a period that is too short re-references without a breakpoint
                if (span > settings.min_length) begin
                    bp                  = tracker.settled_pos + 1'b1;
                    tracker.last_bp     = bp;
                    period_day          = rising;
                    verdict.found       = 1'b1;
                    verdict.bp_pos      = bp;
                    verdict.is_day      = rising;
                end
                settle_reference(pos, br);
            end
        end
        return verdict;
    endfunction

    task automatic compare_field(input string field, input logic [POS_W-1:0] want,
                                 input logic [POS_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", field, want, got);
            o_fail_count++;
        end
    endtask

    // watch both channels and the register port at every rising edge
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            settings = '{tolerance: TOLERANCE_RST, excursions: EXCURSIONS_RST,
                         min_length: MIN_LENGTH_RST, first_pos: FIRST_POS_RST};
            tracker      = '0;
            period_day   = 1'b0;
            expected_verdicts.delete();
            o_fail_count = 0;
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TOLERANCE:  settings.tolerance  = i_cfg_data[BRIGHT_W-1:0];
                    CFG_EXCURSIONS: settings.excursions = i_cfg_data[CNT_W-1:0];
                    CFG_MIN_LENGTH: settings.min_length = i_cfg_data[POS_W-1:0];
                    CFG_FIRST_POS:  settings.first_pos  = i_cfg_data[POS_W-1:0];
                    default: ;
                endcase
            end
            // result transaction against the oldest verdict
            if (i_out_valid && !i_out_stall) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result transaction with no frame outstanding");
                    o_fail_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    compare_field("breakpoint_found", POS_W'(want.found),
                                  POS_W'(i_breakpoint_found));
                    compare_field("breakpoint_position", want.bp_pos,
                                  i_breakpoint_position);
                    compare_field("new_period_is_day", POS_W'(want.is_day),
                                  POS_W'(i_new_period_is_day));
                    compare_field("frame_skipped", POS_W'(want.skipped),
                                  POS_W'(i_frame_skipped));
                end
            end
            // frame transaction
            if (i_in_valid && !i_in_stall)
                expected_verdicts.insert(expected_verdicts.size(),
                                         judge_frame(i_frame_position, i_frame_brightness));
        end
        o_pending = expected_verdicts.size();
    end

endmodule

// ===== verif/day_night_transition_detector_tb.sv =====
module day_night_transition_detector_tb;
    import dntd_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_OFF     = 60;
    localparam int PHASES       = 9;
    localparam int PHASE_FRAMES = 160;
    localparam int POS_TOP      = 24'hFFFFFF;

    logic                 i_clk              = 1'b0;
    logic                 i_rst_n            = 1'b0;
    logic                 i_in_valid         = 1'b0;
    logic                 o_in_stall;
    logic [POS_W-1:0]     i_frame_position   = '0;
    logic [BRIGHT_W-1:0]  i_frame_brightness = '0;
    logic                 o_out_valid;
    logic                 i_out_stall        = 1'b0;
    logic                 o_breakpoint_found;
    logic [POS_W-1:0]     o_breakpoint_position;
    logic                 o_new_period_is_day;
    logic                 o_frame_skipped;
    logic                 i_cfg_we           = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index        = '0;
    logic [CFG_W-1:0]     i_cfg_data         = '0;

    int   fail_count;
    int   pending_verdicts;
    int   cycle_count   = 0;
    int   max_pos       = 0;
    int   tol_now       = 2560;
    logic steady_flow   = 1'b0;
    logic pressure_req  = 1'b0;

    logic [CFG_IDX_W-1:0] reg_ids [4] = '{CFG_TOLERANCE, CFG_EXCURSIONS,
                                          CFG_MIN_LENGTH, CFG_FIRST_POS};

    day_night_transition_detector dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_frame_position      (i_frame_position),
        .i_frame_brightness    (i_frame_brightness),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_breakpoint_found    (o_breakpoint_found),
        .o_breakpoint_position (o_breakpoint_position),
        .o_new_period_is_day   (o_new_period_is_day),
        .o_frame_skipped       (o_frame_skipped),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data)
    );

    day_night_transition_detector_checker checker_inst (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .i_in_stall            (o_in_stall),
        .i_frame_position      (i_frame_position),
        .i_frame_brightness    (i_frame_brightness),
        .i_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .i_breakpoint_found    (o_breakpoint_found),
        .i_breakpoint_position (o_breakpoint_position),
        .i_new_period_is_day   (o_new_period_is_day),
        .i_frame_skipped       (o_frame_skipped),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .o_fail_count          (fail_count),
        .o_pending             (pending_verdicts)
    );

    // clock
    always #10 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_idle();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_flow || roll < 65)
            return 0;
        else if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int clamp_bright(input int v);
        if (v < 0)
            return 0;
        if (v > 65535)
            return 65535;
        return v;
    endfunction

    // one frame transaction, after a random gap
    task automatic send_frame(input int pos, input int br);
        int gap;
        gap = pick_idle();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_frame_position   <= POS_W'(pos);
        i_frame_brightness <= BRIGHT_W'(br);
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        if (pos > max_pos)
            max_pos = pos;
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_verdicts != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // write all four registers on consecutive cycles
    task automatic apply_settings(input int tol, input int req, input int min_len,
                                  input int first);
        int values [4];
        values = '{tol, req, min_len, first};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= reg_ids[i];
            i_cfg_data  <= CFG_W'(values[i]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        tol_now  = tol;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (pressure_req) begin
                pressure_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF - 1) @(negedge i_clk);
            end else begin
                n = pick_idle();
                if (n == 0) begin
                    i_out_stall <= 1'b0;
                end else begin
                    i_out_stall <= 1'b1;
                    repeat (n - 1) @(negedge i_clk);
                end
            end
        end
    end

    // stimulus and verdict
    initial begin
        int roll;
        int cursor;
        int first;
        int level;
        int amp;
        int back;
        int tol;
        int req;
        int min_len;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: start, skip, tolerance edge, day and night breakpoints, short period
        send_frame(5, 16'h1000);
        send_frame(0, 16'h1000);
        send_frame(0, 16'h1000);
        send_frame(1, 16'h1000 + 2560);
        send_frame(150, 16'hFFFF);
        send_frame(151, 16'hFFFF);
        send_frame(152, 16'hFFFF);
        send_frame(2, 16'h0000);
        send_frame(153, 16'h0000);
        send_frame(154, 16'h0000);
        send_frame(155, 16'h0000);
        send_frame(160, 16'h0A00);
        send_frame(161, 16'h8000);
        send_frame(162, 16'h8000);
        send_frame(163, 16'h8000);
        drain_results();

        // directed: zero tolerance, count left above a lowered requirement
        apply_settings(0, 255, 0, 0);
        for (int i = 170; i < 174; i++)
            send_frame(i, 16'h8001);
        drain_results();
        apply_settings(0, 2, 0, 0);
        send_frame(174, 16'h8002);
        send_frame(175, 16'h8000);
        send_frame(176, 16'h7000);
        send_frame(177, 16'h7000);
        drain_results();

        // counter saturation: build up to one short of the limit, then lower it
        first = max_pos + 1 + $urandom_range(0, 16'hFFFF);
        apply_settings(0, 255, 50, first);
        send_frame(first, 16'h4000);
        for (int i = 1; i <= 254; i++)
            send_frame(first + i, 16'hC000);
        drain_results();
        apply_settings(0, 3, 50, first);
        cursor = first + 254;
        for (int i = 0; i < 4; i++) begin
            cursor++;
            send_frame(cursor, 16'hC000);
        end
        cursor++;
        send_frame(cursor, 16'h4000);
        drain_results();

        // random phases: frame sequences with transitions, plus rewinds and strays
        for (int p = 0; p < PHASES; p++) begin
            if (p == 5)
                first = 24'h800000 + $urandom_range(0, 16'hFFFF);
            else
                first = max_pos + 1 + $urandom_range(0, 18'h3FFFF);
            case (p)
                2:       tol = 0;
                3:       tol = 65535;
                default: tol = $urandom_range(16'h0080, 16'h1800);
            endcase
            case (p)
                4:       req = 255;
                6:       req = 1;
                default: req = $urandom_range(1, 6);
            endcase
            case (p)
                7:       min_len = POS_TOP;
                8:       min_len = 0;
                default: min_len = $urandom_range(0, 40);
            endcase
            apply_settings(tol, req, min_len, first);
            steady_flow = (p % 3 == 1);
            if (p == 1)
                pressure_req = 1'b1;

            level  = $urandom_range(0, 65535);
            cursor = first;
            send_frame(cursor, level);
            amp = tol_now >> 1;
            if (amp > 16'h1000)
                amp = 16'h1000;
            for (int k = 0; k < PHASE_FRAMES; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 80) begin
                    // steady run, now and then a shift to a new level
                    if (roll < 8)
                        level = $urandom_range(0, 65535);
                    cursor += ($urandom_range(0, 9) == 0) ? $urandom_range(2, 5) : 1;
                    send_frame(cursor, clamp_bright(level + int'($urandom_range(0, 2 * amp))
                                                    - amp));
                end else if (roll < 88) begin
                    // single-frame flicker
                    cursor++;
                    send_frame(cursor, $urandom_range(0, 65535));
                end else if (roll < 94) begin
                    // caller rewinds and replays
                    back   = $urandom_range(1, 40);
                    cursor = (cursor - back < first) ? first : cursor - back;
                    send_frame(cursor, clamp_bright(level + int'($urandom_range(0, 2 * amp))
                                                    - amp));
                end else begin
                    // stray frame somewhere in the visited range
                    send_frame($urandom_range(0, max_pos), $urandom_range(0, 65535));
                end
            end
            drain_results();
        end
        steady_flow = 1'b0;

        // last position: the reference lands at the top, everything after is skipped
        apply_settings(2560, 3, 100, POS_TOP);
        send_frame(POS_TOP, $urandom_range(0, 65535));
        for (int i = 0; i < 8; i++)
            send_frame($urandom_range(0, POS_TOP), $urandom_range(0, 65535));
        drain_results();

        if (fail_count == 0 && pending_verdicts == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
